>>> src/wda_pkg.sv
// Package for the weighted distance activation block.
// Holds the shared widths, constants, queue entry types and the back end state codes.
// Depends on nothing.
package wda_pkg;

    localparam int SUM_W   = 38;
    localparam int DIST_W  = 19;
    localparam int ACT_W   = 16;
    localparam int ELEM_W  = 16;
    localparam int SQ_W    = 32;
    localparam int SCALE_W = 16;
    localparam int FRAC_W  = 15;

    localparam logic [SCALE_W-1:0] SCALE_ONE = 16'hFFFF;
    localparam logic [SCALE_W-1:0] SCALE_095 = 16'd62259;
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
    localparam logic [ACT_W-1:0]   TANH_ONE  = 16'd32768;
    localparam logic [DIST_W-1:0]  DIST_SAT  = 19'd32768;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam int ROOT_STEPS = 19;
    localparam int DIV_STEPS  = 31;
    localparam int STEP_W     = 5;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             eq;
    } wda_dist_t;

    typedef struct packed {
        logic      valid;
        wda_dist_t data;
    } wda_push_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_ROOT,
        B_LOOK,
        B_RDLO,
        B_RDHI,
        B_MULT,
        B_MIX,
        B_DIV,
        B_OUT
    } wda_back_state_t;

endpackage

>>> src/weighted_distance_activation.sv
// Top level of the weighted distance activation block.
// Instantiates wda_front, wda_fifo and wda_back; depends on wda_pkg.
//
//  Channel   Direction  Handshake                  Payload
//  s_axis    in         s_axis_tvalid/tready       tdata: weight, pattern; tlast: last element
//  m_axis    out        m_axis_tvalid/tready       tdata: sum, root, activation, all equal
//  cfg       in         cfg_we                     cfg_wdata: distance mode
//
// Elements are taken one per cycle while s_axis_tready is high; a finished sum passes the
// p0, p1 and p2 registers before it enters the queue. The back end takes each vector alone
// through 19 root steps, tanh reads and 31 reciprocal steps; this sets the short vector rate.
// The input stalls only when the four-entry queue and the sums in flight fill it.
// Reset is asynchronous and clears the mode, the accumulator and all control state.
module weighted_distance_activation
    import wda_pkg::*;
#(
    parameter int TANH_TABLE_ENTRIES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // weight_elem [15:0], pattern_elem [31:16]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // squared_dist, dist_res, activation, all_equal, zeros
    input  logic        cfg_we,
    input  logic        cfg_wdata
);

    logic               mode_reg;
    wda_push_t          push;
    wda_dist_t          head;
    logic               pop;
    logic               empty;
    logic [FIFO_CW-1:0] fifo_count;
    logic [SUM_W-1:0]   out_sum;
    logic [DIST_W-1:0]  out_dist;
    logic [ACT_W-1:0]   out_act;
    logic               out_eq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= 1'b0;
        else if (cfg_we)
            mode_reg <= cfg_wdata;
    end

    wda_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_weight  (s_axis_tdata[15:0]),
        .in_pattern (s_axis_tdata[31:16]),
        .in_last    (s_axis_tlast),
        .mode       (mode_reg),
        .fifo_count (fifo_count),
        .push       (push)
    );

    wda_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .empty (empty),
        .count (fifo_count)
    );

    wda_back #(
        .TANH_TABLE_ENTRIES (TANH_TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_sum   (out_sum),
        .out_dist  (out_dist),
        .out_act   (out_act),
        .out_eq    (out_eq)
    );

    assign m_axis_tdata = {6'b0, out_eq, out_act, out_dist, out_sum};

    a_no_overflow : assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (fifo_count < FIFO_CW'(FIFO_DEPTH) || pop))
        else $error("A sum was pushed into a full queue.");

    a_act_range : assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_act <= TANH_ONE))
        else $error("Activation is above one.");

    a_equal_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_eq) |-> (out_sum == '0 && out_act == TANH_ONE))
        else $error("Equal vectors gave a non-zero distance.");

    a_pop_ok : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("The queue was read while empty.");

endmodule

>>> src/wda_front.sv
// Front end: takes element pairs, forms weighted squared differences and accumulates them.
// Pushes one finished sum per vector into the queue. Depends on wda_pkg.
module wda_front
    import wda_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic signed [ELEM_W-1:0] in_weight,
    input  logic signed [ELEM_W-1:0] in_pattern,
    input  logic                     in_last,
    input  logic                     mode,
    input  logic [FIFO_CW-1:0]       fifo_count,
    output wda_push_t                push
);

    logic                accept;
    logic signed [ELEM_W:0] diff;
    logic [ELEM_W:0]     diff_abs;
    logic [31:0]         scale_prod;
    logic [47:0]         term_prod;
    logic [SQ_W-1:0]     term;
    logic [SUM_W:0]      sum_wide;
    logic [SUM_W-1:0]    sum_sat;
    logic [FIFO_CW:0]    occupied;

    logic [SCALE_W-1:0]  scale_reg, scale_next;
    logic                p0_valid_reg, p1_valid_reg, p2_valid_reg;
    logic                p0_last_reg, p1_last_reg, p2_last_reg;
    logic                p0_eq_reg, p1_eq_reg, p2_eq_reg;
    logic                p0_mode_reg, p1_mode_reg;
    logic [SCALE_W-1:0]  p0_scale_reg, p1_scale_reg;
    logic [ELEM_W-1:0]   p0_ad_reg;
    logic [SQ_W-1:0]     p1_sq_reg;
    logic [SQ_W-1:0]     p2_term_reg;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic                eq_reg, eq_next;

    assign occupied = {1'b0, fifo_count}
                    + {{FIFO_CW{1'b0}}, p0_valid_reg & p0_last_reg}
                    + {{FIFO_CW{1'b0}}, p1_valid_reg & p1_last_reg}
                    + {{FIFO_CW{1'b0}}, p2_valid_reg & p2_last_reg};
    assign in_ready = (occupied < (FIFO_CW+1)'(FIFO_DEPTH));
    assign accept   = in_valid & in_ready;

    assign diff     = {in_weight[ELEM_W-1], in_weight} - {in_pattern[ELEM_W-1], in_pattern};
    assign diff_abs = diff[ELEM_W] ? (ELEM_W+1)'(-diff) : diff;

    assign scale_prod = 32'(scale_reg * SCALE_095) + 32'd32768;

    always_comb
    begin
        scale_next = scale_reg;
        if (accept)
        begin
            if (in_last)
                scale_next = SCALE_ONE;
            else if (mode)
                scale_next = scale_prod[31:16];
        end
    end

    assign term_prod = 48'(p1_sq_reg * p1_scale_reg) + 48'd32768;
    assign term      = p1_mode_reg ? term_prod[47:16] : p1_sq_reg;

    assign sum_wide = {1'b0, sum_reg} + {{(SUM_W-SQ_W+1){1'b0}}, p2_term_reg};
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    always_comb
    begin
        sum_next = sum_reg;
        eq_next  = eq_reg;
        if (p2_valid_reg)
        begin
            if (p2_last_reg)
            begin
                sum_next = '0;
                eq_next  = 1'b1;
            end
            else
            begin
                sum_next = sum_sat;
                eq_next  = eq_reg & p2_eq_reg;
            end
        end
    end

    assign push.valid    = p2_valid_reg & p2_last_reg;
    assign push.data.sum = sum_sat;
    assign push.data.eq  = eq_reg & p2_eq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg    <= SCALE_ONE;
            sum_reg      <= '0;
            eq_reg       <= 1'b1;
            p0_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else
        begin
            scale_reg    <= scale_next;
            sum_reg      <= sum_next;
            eq_reg       <= eq_next;
            p0_valid_reg <= accept;
            p1_valid_reg <= p0_valid_reg;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p0_ad_reg    <= diff_abs[ELEM_W-1:0];
        p0_eq_reg    <= (in_weight == in_pattern);
        p0_last_reg  <= in_last;
        p0_mode_reg  <= mode;
        p0_scale_reg <= scale_reg;
        p1_sq_reg    <= SQ_W'(p0_ad_reg * p0_ad_reg);
        p1_eq_reg    <= p0_eq_reg;
        p1_last_reg  <= p0_last_reg;
        p1_mode_reg  <= p0_mode_reg;
        p1_scale_reg <= p0_scale_reg;
        p2_term_reg  <= term;
        p2_eq_reg    <= p1_eq_reg;
        p2_last_reg  <= p1_last_reg;
    end

endmodule

>>> src/wda_fifo.sv
// Short queue of finished sums between the front and back ends.
// Depends on wda_pkg.
module wda_fifo
    import wda_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  wda_push_t          push,
    input  logic               pop,
    output wda_dist_t          head,
    output logic               empty,
    output logic [FIFO_CW-1:0] count
);

    wda_dist_t            mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0]   count_reg, count_next;

    assign head  = mem[rd_ptr_reg];
    assign empty = (count_reg == '0);
    assign count = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push.valid && !pop)
            count_next = count_reg + 1'b1;
        else if (!push.valid && pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push.valid)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
            mem[wr_ptr_reg] <= push.data;
    end

endmodule

>>> src/wda_back.sv
// Back end: square root, interpolated tanh lookup and reciprocal for one sum at a time.
// Holds the result in an output register until it is taken. Depends on wda_pkg.
module wda_back
    import wda_pkg::*;
#(
    parameter int TANH_TABLE_ENTRIES = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  wda_dist_t         head,
    input  logic              empty,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [SUM_W-1:0]  out_sum,
    output logic [DIST_W-1:0] out_dist,
    output logic [ACT_W-1:0]  out_act,
    output logic              out_eq
);

    localparam int AW = $clog2(TANH_TABLE_ENTRIES + 1);
    localparam int PW = FRAC_W + AW;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam logic [63:0] STEP_H  = (64'd8 << 30) / TANH_TABLE_ENTRIES;

    function automatic logic [(TANH_TABLE_ENTRIES+1)*16-1:0] build_tanh(input logic [63:0] h);
        logic [(TANH_TABLE_ENTRIES+1)*16-1:0] tab;
        logic [63:0] h2, a, th, t, num, den, rem, q, r;
        tab = '0;
        h2  = (h * h) >> 30;
        a   = 64'd23482185;
        a   = 64'd57947971 - ((h2 * a) >> 30);
        a   = 64'd143165577 - ((h2 * a) >> 30);
        a   = 64'd357913941 - ((h2 * a) >> 30);
        a   = ONE_Q30 - ((h2 * a) >> 30);
        th  = (h * a) >> 30;
        t   = '0;
        for (int i = 1; i <= TANH_TABLE_ENTRIES; i++)
        begin
            num = (t + th) << 30;
            den = ONE_Q30 + ((t * th) >> 30);
            rem = '0;
            q   = '0;
            for (int j = 63; j >= 0; j--)
            begin
                rem = {rem[62:0], num[j]};
                if (rem >= den)
                begin
                    rem  = rem - den;
                    q[j] = 1'b1;
                end
            end
            t = (q > ONE_Q30) ? ONE_Q30 : q;
            r = (t + 64'd16384) >> 15;
            tab[i*16 +: 16] = r[15:0];
        end
        return tab;
    endfunction

    localparam logic [(TANH_TABLE_ENTRIES+1)*16-1:0] TANH_ROM = build_tanh(STEP_H);

    wda_back_state_t     state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SUM_W-1:0]    sum_reg;
    logic                eq_reg;
    logic [SUM_W-1:0]    rem_reg, rem_next;
    logic [SUM_W-1:0]    root_reg, root_next;
    logic [SUM_W-1:0]    bit_reg, bit_next;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    logic [ACT_W-1:0]    lo_reg, hi_reg;
    logic [30:0]         prod_reg, prod_next;
    logic [16:0]         den_reg, den_next;
    logic [30:0]         num_reg, num_next;
    logic [17:0]         drem_reg, drem_next;
    logic [ACT_W-1:0]    act_reg, act_next;
    logic [ACT_W-1:0]    th_val;
    logic [SUM_W-1:0]    trial;
    logic [PW-1:0]       pos;
    logic [ACT_W-1:0]    diff_lh;
    logic [17:0]         drem_shift;
    logic [31:0]         th_sum;

    assign trial      = root_reg + bit_reg;
    assign pos        = PW'(root_reg[FRAC_W-1:0]) * PW'(TANH_TABLE_ENTRIES);
    assign diff_lh    = (hi_reg > lo_reg) ? hi_reg - lo_reg : '0;
    assign th_sum     = 32'(lo_reg) + 32'((prod_reg + 31'd16384) >> 15);
    assign th_val     = th_sum[ACT_W-1:0];
    assign drem_shift = {drem_reg[16:0], num_reg[30]};

    assign pop       = (state_reg == B_IDLE) && !empty;
    assign out_valid = (state_reg == B_OUT);
    assign out_sum   = sum_reg;
    assign out_dist  = root_reg[DIST_W-1:0];
    assign out_act   = act_reg;
    assign out_eq    = eq_reg;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        bit_next   = bit_reg;
        idx_next   = idx_reg;
        frac_next  = frac_reg;
        prod_next  = prod_reg;
        den_next   = den_reg;
        num_next   = num_reg;
        drem_next  = drem_reg;
        act_next   = act_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    rem_next   = head.sum;
                    root_next  = '0;
                    bit_next   = SUM_W'(1) << (2 * (ROOT_STEPS - 1));
                    step_next  = STEP_W'(ROOT_STEPS - 1);
                    state_next = B_ROOT;
                end
            end
            B_ROOT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next  = rem_reg - trial;
                    root_next = (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_next = root_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                    state_next = B_LOOK;
            end
            B_LOOK:
            begin
                idx_next  = pos[PW-1:FRAC_W];
                frac_next = pos[FRAC_W-1:0];
                if (root_reg[DIST_W-1:0] >= DIST_SAT)
                begin
                    den_next   = 17'(TANH_ONE) + {TANH_ONE, 1'b0};
                    num_next   = 31'(ONE_Q30) + 31'(({TANH_ONE, 1'b0} + 17'(TANH_ONE)) >> 1);
                    drem_next  = '0;
                    act_next   = '0;
                    step_next  = STEP_W'(DIV_STEPS - 1);
                    state_next = B_DIV;
                end
                else
                begin
                    state_next = B_RDLO;
                end
            end
            B_RDLO:
            begin
                state_next = B_RDHI;
            end
            B_RDHI:
            begin
                state_next = B_MULT;
            end
            B_MULT:
            begin
                prod_next  = 31'(diff_lh * frac_reg);
                state_next = B_MIX;
            end
            B_MIX:
            begin
                den_next   = 17'(TANH_ONE) + {th_val, 1'b0};
                num_next   = 31'(ONE_Q30) + 31'((17'(TANH_ONE) + {th_val, 1'b0}) >> 1);
                drem_next  = '0;
                act_next   = '0;
                step_next  = STEP_W'(DIV_STEPS - 1);
                state_next = B_DIV;
            end
            B_DIV:
            begin
                num_next = {num_reg[29:0], 1'b0};
                if (drem_shift >= {1'b0, den_reg})
                begin
                    drem_next = drem_shift - {1'b0, den_reg};
                    act_next  = {act_reg[ACT_W-2:0], 1'b1};
                end
                else
                begin
                    drem_next = drem_shift;
                    act_next  = {act_reg[ACT_W-2:0], 1'b0};
                end
                step_next = step_reg - 1'b1;
                if (step_reg == '0)
                    state_next = B_OUT;
            end
            B_OUT:
            begin
                if (out_ready)
                    state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        root_reg <= root_next;
        bit_reg  <= bit_next;
        idx_reg  <= idx_next;
        frac_reg <= frac_next;
        prod_reg <= prod_next;
        den_reg  <= den_next;
        num_reg  <= num_next;
        drem_reg <= drem_next;
        act_reg  <= act_next;
        if (pop)
        begin
            sum_reg <= head.sum;
            eq_reg  <= head.eq;
        end
        if (state_reg == B_RDLO)
            lo_reg <= TANH_ROM[idx_reg*16 +: 16];
        if (state_reg == B_RDHI)
            hi_reg <= TANH_ROM[(idx_reg + 1'b1)*16 +: 16];
    end

endmodule

>>> verif/wda_checker.sv
// Checker for the weighted distance activation block: watches the element and result
// transfers and the mode writes, predicts each result and compares it field by field.
// Depends on wda_pkg for the widths and constants.
module wda_checker
    import wda_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [79:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_TANH = 256;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [DIST_W-1:0] root_val;
        logic [ACT_W-1:0]  act;
        logic              eq;
    } dist_result_t;

    dist_result_t      results_due[$];
    logic [15:0]       tanh_points[0:N_TANH];
    logic              weighted;
    logic [SUM_W-1:0]  acc;
    logic [15:0]       scale;
    logic              same;

    function automatic logic [63:0] root_floor(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [31:0] tanh_of(logic [31:0] d);
        logic [63:0] pos;
        logic [63:0] fr;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] df;
        int          idx;
        if (d >= (32'd8 << 12)) return TANH_ONE;
        pos = d * N_TANH;
        idx = int'(pos >> 15);
        fr = pos & 64'h7FFF;
        if (idx >= N_TANH) return TANH_ONE;
        lo = tanh_points[idx];
        hi = tanh_points[idx + 1];
        df = hi > lo ? hi - lo : 0;
        return 32'(lo + ((df * fr + 16384) >> 15));
    endfunction

    initial
    begin
        logic [63:0] h;
        logic [63:0] h2;
        logic [63:0] a;
        logic [63:0] t;
        logic [63:0] step;
        h = (64'd8 << 30) / N_TANH;
        h2 = (h * h) >> 30;
        a = 23482185;
        a = 57947971 - ((h2 * a) >> 30);
        a = 143165577 - ((h2 * a) >> 30);
        a = 357913941 - ((h2 * a) >> 30);
        a = (64'd1 << 30) - ((h2 * a) >> 30);
        step = (h * a) >> 30;
        t = 0;
        tanh_points[0] = 0;
        for (int i = 1; i <= N_TANH; i++)
        begin
            t = ((t + step) << 30) / ((64'd1 << 30) + ((t * step) >> 30));
            if (t > (64'd1 << 30)) t = 64'd1 << 30;
            tanh_points[i] = 16'((t + (64'd1 << 14)) >> 15);
        end
    end

    task automatic take_element(logic signed [15:0] w, logic signed [15:0] p, logic last);
        logic signed [16:0] df;
        logic [63:0]        sq;
        logic [63:0]        term;
        logic [63:0]        total;
        logic [31:0]        th;
        logic [31:0]        den;
        dist_result_t       r;
        df = 17'(w) - 17'(p);
        if (df < 0) df = -df;
        sq = 64'(df) * 64'(df);
        if (weighted)
        begin
            term = (sq * scale + 32768) >> 16;
            scale = 16'((64'(scale) * SCALE_095 + 32768) >> 16);
        end
        else
            term = sq;
        total = 64'(acc) + term;
        acc = total > 64'(SUM_MAX) ? SUM_MAX : total[SUM_W-1:0];
        if (w != p) same = 1'b0;
        if (last)
        begin
            r.sum = acc;
            r.root_val = DIST_W'(root_floor(64'(acc)));
            th = tanh_of(32'(r.root_val));
            den = 32768 + 2 * th;
            r.act = ACT_W'(((32'd1 << 30) + den / 2) / den);
            r.eq = same;
            results_due.push_back(r);
            acc = 0;
            scale = SCALE_ONE;
            same = 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        dist_result_t got;
        dist_result_t want;
        if (!rst_n)
        begin
            weighted = 1'b0;
            acc = 0;
            scale = SCALE_ONE;
            same = 1'b1;
            fail_count = 0;
            results_due.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.sum = m_axis_tdata[37:0];
                got.root_val = m_axis_tdata[56:38];
                got.act = m_axis_tdata[72:57];
                got.eq = m_axis_tdata[73];
                if (results_due.size() == 0)
                begin
                    $error("unexpected result transfer, tdata %h", m_axis_tdata);
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got.sum !== want.sum)
                    begin
                        $error("squared_dist: expected %0d, got %0d", want.sum, got.sum);
                        fail_count++;
                    end
                    if (got.root_val !== want.root_val)
                    begin
                        $error("dist_res: expected %0d, got %0d", want.root_val,
                               got.root_val);
                        fail_count++;
                    end
                    if (got.act !== want.act)
                    begin
                        $error("activation: expected %0d, got %0d", want.act, got.act);
                        fail_count++;
                    end
                    if (got.eq !== want.eq)
                    begin
                        $error("all_equal: expected %0d, got %0d", want.eq, got.eq);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                take_element(s_axis_tdata[15:0], s_axis_tdata[31:16], s_axis_tlast);
            if (cfg_we)
                weighted = cfg_wdata;
        end
        pending = results_due.size();
    end

endmodule

>>> verif/tb_top.sv
// Top of the weighted distance activation testbench: clock, reset, element and mode
// stimulus, result back-pressure and the verdict. Depends on wda_pkg, wda_checker and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        cfg_we;
    logic        cfg_wdata;
    int          fail_count;
    int          pending;
    int          quiet_cycles;
    int          ready_gap;

    weighted_distance_activation dut (.*);

    wda_checker u_checker (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 70);
    endfunction

    function automatic logic [15:0] random_elem();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 64)) - 32);
            default: return 16'($urandom());
        endcase
    endfunction

    task automatic send_element(logic [15:0] w, logic [15:0] p, logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {p, w};
        s_axis_tlast <= last;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic idle_cycles(int n);
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic set_mode(logic m);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (80) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_vector(bit burst);
        int len;
        logic [15:0] w;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 90) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
        begin
            w = random_elem();
            send_element(w, ($urandom_range(0, 3) == 0) ? w : random_elem(), i == len - 1);
            if (!burst) idle_cycles(gap_length());
        end
    endtask

    always @(posedge clk)
    begin
        if (ready_gap > 0)
        begin
            m_axis_tready <= 1'b0;
            ready_gap <= ready_gap - 1;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            ready_gap <= ($urandom_range(0, 3) == 0) ? gap_length() : 0;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 1'b0;
        quiet_cycles = 0;
        ready_gap = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int m = 0; m < 2; m++)
        begin
            set_mode(m[0]);
            send_element(16'h0000, 16'h0000, 1'b1);
            send_element(16'h7FFF, 16'h8000, 1'b1);
            send_element(16'h8000, 16'h7FFF, 1'b1);
            send_element(16'h1234, 16'h1234, 1'b0);
            send_element(16'hFFFF, 16'hFFFF, 1'b1);
            send_element(16'h0001, 16'h0000, 1'b1);
            send_element(16'h0000, 16'h4000, 1'b1);
            send_element(16'h0000, 16'h8000, 1'b0);
            send_element(16'h7FFF, 16'h8000, 1'b1);
        end
        // Mode change inside a vector, then a long vector in plain mode whose distance saturates.
        send_element(16'h1000, 16'h0000, 1'b0);
        set_mode(1'b0);
        send_element(16'h1000, 16'h0000, 1'b1);
        for (int i = 0; i < 20; i++)
            send_element(16'h7FFF, 16'h8000, i == 19);

        for (int n = 0; n < 105; n++)
        begin
            if (n % 35 == 34) set_mode(1'($urandom()));
            random_vector((n % 50) < 8);
        end
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
